@@ sv/assert_macros.svh @@
// Assertion macros used by the modulator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/mfsk_pkg.sv @@
// Package with types, constants and the sine table of the MFSK modulator.
`default_nettype none
package mfsk_pkg;
  localparam int TableDepth = 256;
  localparam int ToneBits = 7;
  localparam int SineEntries = 1024;
  localparam int SineBits = $clog2(SineEntries);
  localparam int IdxBits = $clog2(TableDepth);
  localparam logic [15:0] FadeMul = 16'd32113;
  localparam logic [15:0] RampStep = 16'd64;
  localparam logic [15:0] AmpFull = 16'd32767;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0, OP_TONE = 2'd1, OP_CW = 2'd2, OP_START = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_BASE = 3'd0, REG_TONE = 3'd1, REG_SYMS = 3'd2, REG_SCNT = 3'd3,
    REG_FADE = 3'd4, REG_CWLEN = 3'd5, REG_DOT = 3'd6, REG_TUNE = 3'd7
  } reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0, MODE_DATA = 2'd1, MODE_END = 2'd2, MODE_CW = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_READY = 3'd0, ST_PHASE = 3'd1, ST_FADE = 3'd2, ST_MUL = 3'd3,
    ST_OUT = 3'd4, ST_FIN = 3'd5
  } ctl_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_index;
    logic [6:0] entry_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic active;
    logic in_cw;
    logic finished;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] base_step;
    logic [31:0] tone_step;
    logic [21:0] symbol_samples;
    logic [8:0] symbol_count;
    logic [15:0] fade_samples;
    logic [7:0] cw_length;
    logic [15:0] cw_dot_samples;
    logic tune_mode;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;   // latch input beat, do table writes / start
    logic phase;  // advance phase, fetch table entries
    logic fade;   // amplitude update
    logic mul;    // sine times amplitude
    logic fin;    // form result and advance counters
  } cmd_t;

  typedef struct packed {
    logic is_tick;
  } sts_t;

  function automatic logic [15:0] sine_val(input logic [SineBits-1:0] k);
    logic [63:0] x, x2, t, s;
    x = ((64'(2 * k) + 64'd1) * 64'd1686629713) >> (SineBits + 1);
    x2 = (x * x) >> 30;
    t = 64'd1073741824 - x2 / 64'd110;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    sine_val = 16'((s * 64'd32767 + 64'd536870912) >> 30);
  endfunction

  typedef logic [15:0] sine_rom_t [SineEntries];
  function automatic sine_rom_t make_rom();
    sine_rom_t r;
    for (int k = 0; k < SineEntries; k++) r[k] = sine_val(SineBits'(k));
    return r;
  endfunction
  localparam sine_rom_t SineRom = make_rom();
endpackage
`default_nettype wire

@@ sv/mfsk_ctrl.sv @@
// Controller sequencing one beat through the datapath steps.
`default_nettype none
module mfsk_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire mfsk_pkg::sts_t sts,
  output mfsk_pkg::cmd_t cmd
);
  import mfsk_pkg::*;
  `include "assert_macros.svh"
  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_READY;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_READY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (sts.is_tick) begin
          cmd.phase = 1'b1;
          state_nxt = ST_FADE;
        end else begin
          state_nxt = ST_READY;
        end
      end
      ST_FADE: begin
        cmd.fade = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_READY;
      end
      default: state_nxt = ST_READY;
    endcase
  end

  `ASSERT_IMPL(a_excl, clk, rst_n, in_ready, !out_valid, "ready and valid together")
  `ASSERT_NEXT(a_take, clk, rst_n, in_valid && in_ready, state_r == ST_PHASE, "take lost")
  `ASSERT_NEXT(a_fin, clk, rst_n, cmd.fin, out_valid, "result not shown")
endmodule
`default_nettype wire

@@ sv/mfsk_dp.sv @@
// Datapath: tables, phase accumulator, amplitude, keying and sine product.
`default_nettype none
module mfsk_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mfsk_pkg::cfg_t cfg,
  input  wire mfsk_pkg::in_beat_t in_data,
  input  wire mfsk_pkg::cmd_t cmd,
  output mfsk_pkg::sts_t sts,
  output mfsk_pkg::out_beat_t out_data
);
  import mfsk_pkg::*;

  logic [ToneBits-1:0] tone_mem [TableDepth];
  logic cw_mem [TableDepth];

  in_beat_t beat_r;
  mode_t mode_r, mode_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [7:0] sym_r, sym_nxt;
  logic [21:0] sis_r, sis_nxt;
  logic [15:0] amp_r, amp_nxt;
  logic [15:0] ramp_r, ramp_nxt;
  logic key_r, key_nxt;
  logic [ToneBits-1:0] tone_rd_r;
  logic cw_rd_r;
  logic [31:0] rem_prod_r;
  logic [15:0] mag_r;
  logic [15:0] ent_r;
  logic [30:0] prod_r;
  logic neg_r, zero_r;
  out_beat_t res_r, res_nxt;

  logic [21:0] ss;
  logic [8:0] cnt;
  logic [15:0] dot;
  logic [8:0] left;
  logic [30:0] fade_p;
  logic [SineBits-1:0] si;
  logic [15:0] m16;

  assign ss = (cfg.symbol_samples == '0) ? 22'd1 : cfg.symbol_samples;
  assign cnt = (cfg.symbol_count == '0) ? 9'd1 :
               (cfg.symbol_count > 9'd256) ? 9'd256 : cfg.symbol_count;
  assign dot = (cfg.cw_dot_samples == '0) ? 16'd1 : cfg.cw_dot_samples;
  assign left = cnt - {1'b0, sym_r};
  assign sts.is_tick = (beat_r.opcode == OP_TICK);
  assign out_data = res_r;

  // Table writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.take && in_data.opcode == OP_TONE)
      tone_mem[in_data.entry_index] <= in_data.entry_value[ToneBits-1:0];
    if (cmd.take && in_data.opcode == OP_CW)
      cw_mem[in_data.entry_index] <= in_data.entry_value[0];
    tone_rd_r <= tone_mem[cfg.tune_mode ? 8'd0 : sym_r];
    cw_rd_r <= cw_mem[sym_r];
  end

  always_comb begin
    fade_p = 31'(amp_r) * 31'(FadeMul);
    si = phase_r[29 -: SineBits];
    if (phase_r[30]) si = ~si;
    m16 = 16'((prod_r + 31'd16384) >> 15);
  end

  always_comb begin
    mode_nxt = mode_r; phase_nxt = phase_r; sym_nxt = sym_r; sis_nxt = sis_r;
    amp_nxt = amp_r; ramp_nxt = ramp_r; key_nxt = key_r; res_nxt = res_r;
    if (cmd.take && in_data.opcode == OP_START) begin
      phase_nxt = '0; sym_nxt = '0; sis_nxt = '0; amp_nxt = AmpFull;
      ramp_nxt = '0; key_nxt = 1'b0; mode_nxt = MODE_DATA;
    end
    if (cmd.phase) begin
      if (mode_r == MODE_DATA)
        phase_nxt = phase_r + cfg.base_step + 32'(tone_rd_r) * cfg.tone_step;
      else if (mode_r == MODE_CW && sym_r < cfg.cw_length)
        phase_nxt = phase_r + cfg.base_step;
    end
    // A symbol index past the count leaves a huge remaining count: no fade.
    if (cmd.fade && mode_r == MODE_DATA && !cfg.tune_mode &&
        ({1'b0, sym_r} <= cnt) &&
        ({rem_prod_r} - 32'(sis_r)) < 32'(cfg.fade_samples))
      amp_nxt = fade_p[30:15];
    if (cmd.fin) begin
      res_nxt = '0;
      unique case (mode_r)
        MODE_IDLE: ;
        MODE_DATA: begin
          res_nxt.sample = zero_r ? 16'sd0 : (neg_r ? -$signed(m16) : $signed(m16));
          res_nxt.active = 1'b1;
          if (!cfg.tune_mode) begin
            if (sis_r + 22'd1 >= ss) begin
              sis_nxt = '0;
              if ({1'b0, sym_r} + 9'd1 >= cnt) mode_nxt = MODE_END;
              else sym_nxt = sym_r + 8'd1;
            end else sis_nxt = sis_r + 22'd1;
          end
        end
        MODE_END: begin
          amp_nxt = '0;
          if (cfg.cw_length == '0) begin
            mode_nxt = MODE_IDLE; res_nxt.finished = 1'b1;
          end else begin
            mode_nxt = MODE_CW; res_nxt.active = 1'b1;
            phase_nxt = '0; ramp_nxt = '0; key_nxt = 1'b0; sym_nxt = '0; sis_nxt = '0;
          end
        end
        MODE_CW: begin
          if (sym_r >= cfg.cw_length) begin
            mode_nxt = MODE_IDLE; res_nxt.finished = 1'b1;
          end else begin
            if (ramp_r != '0)
              res_nxt.sample = neg_r ? -$signed(m16) : $signed(m16);
            res_nxt.active = 1'b1; res_nxt.in_cw = 1'b1;
            if ((ramp_r != '0 && ramp_r != 16'h8000) || cw_rd_r != key_r)
              ramp_nxt = ramp_r + RampStep;
            key_nxt = cw_rd_r;
            if (sis_r + 22'd1 >= 22'(dot)) begin
              sis_nxt = '0; sym_nxt = sym_r + 8'd1;
            end else sis_nxt = sis_r + 22'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Fade window remaining count and product pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.take) beat_r <= in_data;
    if (cmd.phase) rem_prod_r <= 32'(left) * 32'(ss);
    if (cmd.fade) begin
      ent_r <= SineRom[si];
      if (mode_r == MODE_CW)
        mag_r <= (ramp_r == 16'h8000) ? AmpFull :
                 (ramp_r[15] ? 16'(17'h10000 - 17'(ramp_r)) : ramp_r);
      else mag_r <= amp_nxt;
    end
    if (cmd.mul) begin
      prod_r <= 31'(mag_r) * 31'(ent_r);
      neg_r <= phase_r[31];
      zero_r <= 1'b0;
    end
    if (cmd.fin) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; phase_r <= '0; sym_r <= '0; sis_r <= '0;
      amp_r <= AmpFull; ramp_r <= '0; key_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; phase_r <= phase_nxt; sym_r <= sym_nxt; sis_r <= sis_nxt;
      amp_r <= amp_nxt; ramp_r <= ramp_nxt; key_r <= key_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/mfsk_tone_modulator_with_cw_id.sv @@
// Top level of the continuous-phase MFSK modulator with CW identification.
// Write and start beats give no result, and the block returns to ready through
// the phase state. A tick beat runs through phase advance, amplitude update
// with the sine table lookup, one shared sine-times-amplitude multiply and
// result formation, then holds its result until the output beat is taken; no
// new beat is taken before that, and an output stall delays it. Tables are
// written by input beats; configuration is written through the cfg port while
// idle, which the user must ensure, as the block itself does not enforce it.
`default_nettype none
module mfsk_tone_modulator_with_cw_id (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire mfsk_pkg::in_beat_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output mfsk_pkg::out_beat_t out_data,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import mfsk_pkg::*;
  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers with their documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_step <= 32'd134217728; cfg_r.tone_step <= '0;
      cfg_r.symbol_samples <= 22'd7680; cfg_r.symbol_count <= 9'd79;
      cfg_r.fade_samples <= 16'd522; cfg_r.cw_length <= '0;
      cfg_r.cw_dot_samples <= 16'd2560; cfg_r.tune_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_BASE: cfg_r.base_step <= cfg_data;
        REG_TONE: cfg_r.tone_step <= cfg_data;
        REG_SYMS: cfg_r.symbol_samples <= cfg_data[21:0];
        REG_SCNT: cfg_r.symbol_count <= cfg_data[8:0];
        REG_FADE: cfg_r.fade_samples <= cfg_data[15:0];
        REG_CWLEN: cfg_r.cw_length <= cfg_data[7:0];
        REG_DOT: cfg_r.cw_dot_samples <= cfg_data[15:0];
        REG_TUNE: cfg_r.tune_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mfsk_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  mfsk_dp u_dp (
    .clk, .rst_n, .cfg(cfg_r), .in_data, .cmd, .sts, .out_data
  );
endmodule
`default_nettype wire
